[rtl/msv_pkg.sv]
package msv_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int PHASE_BITS_DEF = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int BASE_BITS = 31;
   localparam logic [BASE_BITS-1:0] BASE_RESET = 31'd39370534;

   localparam int NOTE_BITS = 7;
   localparam int VEL_BITS = 7;
   localparam int KIND_BITS = 4;
   localparam int GAIN_BITS = 15;
   localparam int GAIN_DEPTH = 128;
   localparam int RATIO_BITS = 17;
   localparam int SEMI_BITS = 4;
   localparam int SEMI_DEPTH = 12;
   localparam int SHIFT_BITS = 5;
   localparam int STEP_PROD_BITS = BASE_BITS + RATIO_BITS;

   localparam logic OP_MIDI = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [KIND_BITS-1:0] KIND_NOTE_ON = 4'h9;

   // 2^(s/12) in q16
   localparam logic [RATIO_BITS-1:0] SEMITONE_Q16 [SEMI_DEPTH] = '{
      17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
      17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
   };

   // note zero: 69 semitones down is octave -6, semitone 3, shift 16 + 6
   localparam logic [SEMI_BITS-1:0] RESET_SEMI = 4'd3;
   localparam logic [SHIFT_BITS-1:0] RESET_SHIFT = 5'd22;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] GAIN_START = 64'd4294967;
   localparam logic [63:0] GAIN_RATIO = 64'd1127612060;

   typedef struct packed {
      logic valid;
      logic active;
      logic [GAIN_BITS-1:0] gain;
   } tick_type;

   // sin(x) on [0, pi/2], q2.30 in and out, truncating taylor series
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t = Q30_ONE;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      t = (x * t) >> 30;
      return (t > Q30_ONE) ? Q30_ONE : t;
   endfunction

   // quarter-wave entry m of a table with 2^tb entries, full scale 2^(sb-1)-1
   function automatic logic [63:0] quarter_sine(input int m, input int tb, input int sb);
      logic [63:0] ang;
      logic [63:0] s;
      logic [63:0] full;
      ang = (64'(m) * PI_Q30) >> (tb - 1);
      s = sin_q30(ang);
      full = (64'd1 << (sb - 1)) - 64'd1;
      return (s * full + (Q30_ONE >> 1)) >> 30;
   endfunction

   // q0.15 gain for velocity k
   function automatic logic [63:0] gain_entry(input int k);
      logic [63:0] g;
      g = GAIN_START;
      for (int i = 0; i < k; i++) begin
         g = (g * GAIN_RATIO + (Q30_ONE >> 1)) >> 30;
      end
      return (g + 64'd65536) >> 17;
   endfunction

endpackage

[rtl/msv_if.sv]
interface msv_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [7:0] status;
   logic [msv_pkg::NOTE_BITS-1:0] data_one;
   logic [msv_pkg::VEL_BITS-1:0] data_two;

   modport source (output valid, output op, output status, output data_one,
                   output data_two, input ready);
   modport sink (input valid, input op, input status, input data_one,
                 input data_two, output ready);
endinterface

interface msv_rsp_if #(
   parameter int SAMPLE_BITS = msv_pkg::SAMPLE_BITS_DEF
);
   logic valid;
   logic ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface msv_csr_if;
   logic valid;
   logic ready;
   logic [msv_pkg::BASE_BITS-1:0] base_increment;

   modport source (output valid, output base_increment, input ready);
   modport sink (input valid, input base_increment, output ready);
endinterface

[rtl/msv_voice.sv]
module msv_voice #(
   parameter int SINE_TABLE_BITS = msv_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS = msv_pkg::PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   msv_req_if.sink                    req,
   msv_csr_if.sink                    csr,
   input  logic                       tick_take,
   output msv_pkg::tick_type          tick,
   output logic [SINE_TABLE_BITS-1:0] tick_idx
);
   import msv_pkg::*;

   localparam logic [7:0] NOTE_OFFSET = 8'd3;        // note - 69 + 72, keeps it positive
   localparam logic [15:0] OCT_RECIP = 16'd171;       // 171 / 2048 ~ 1 / 12
   localparam int OCT_RECIP_SHIFT = 11;
   localparam logic [7:0] SEMIS_PER_OCT = 8'd12;
   localparam logic [SHIFT_BITS-1:0] SHIFT_TOP = 5'd22;
   localparam logic [STEP_PROD_BITS-1:0] STEP_HALF =
      STEP_PROD_BITS'(1) << (PHASE_BITS - 1);

   // input register
   logic                  s0_valid_ff;
   logic                  s0_op_ff;
   logic [KIND_BITS-1:0]  s0_kind_ff;
   logic [NOTE_BITS-1:0]  s0_note_ff;
   logic [VEL_BITS-1:0]   s0_vel_ff;
   logic [RATIO_BITS-1:0] s0_ratio_ff;
   logic [SHIFT_BITS-1:0] s0_shift_ff;

   // voice state
   logic                  active_ff, active_in;
   logic [NOTE_BITS-1:0]  note_ff, note_in;
   logic [VEL_BITS-1:0]   vel_ff, vel_in;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic [SHIFT_BITS-1:0] shift_ff, shift_in;
   logic [BASE_BITS-1:0]  base_ff, base_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;

   tick_type                   tick_ff, tick_in;
   logic [SINE_TABLE_BITS-1:0] idx_ff;

   logic [GAIN_BITS-1:0] gain_rom [GAIN_DEPTH];

   logic s0_is_tick, s0_go, s0_room, s1_room, req_go, csr_go;
   logic [7:0]                dec_v;
   logic [15:0]               dec_prod;
   logic [3:0]                dec_oct;
   logic [SEMI_BITS-1:0]      dec_semi;
   logic [STEP_PROD_BITS-1:0] step_prod, step_shifted;

   for (genvar g = 0; g < GAIN_DEPTH; g++) begin : g_gain
      assign gain_rom[g] = GAIN_BITS'(gain_entry(g));
   end

   assign s1_room = !tick_ff.valid || tick_take;
   assign s0_is_tick = (s0_op_ff == OP_TICK);
   assign s0_go = s0_valid_ff && (!s0_is_tick || s1_room);
   assign s0_room = !s0_valid_ff || s0_go;
   assign req.ready = s0_room && !reset;
   assign req_go = req.valid && req.ready;
   assign csr.ready = !reset;
   assign csr_go = csr.valid && csr.ready;

   // split the note into octave and semitone ahead of the state update
   always_comb begin
      dec_v = 8'(req.data_one) + NOTE_OFFSET;
      dec_prod = 16'(dec_v) * OCT_RECIP;
      dec_oct = 4'(dec_prod >> OCT_RECIP_SHIFT);
      dec_semi = SEMI_BITS'(dec_v - 8'(dec_oct) * SEMIS_PER_OCT);
   end

   // next state carries reset so the step register always matches it
   always_comb begin
      active_in = active_ff;
      note_in = note_ff;
      vel_in = vel_ff;
      ratio_in = ratio_ff;
      shift_in = shift_ff;
      base_in = base_ff;
      phase_in = phase_ff;
      if (csr_go) begin
         base_in = csr.base_increment;
      end
      if (s0_go) begin
         if (!s0_is_tick) begin
            if (s0_kind_ff == KIND_NOTE_ON) begin
               note_in = s0_note_ff;
               vel_in = s0_vel_ff;
               active_in = 1'b1;
               ratio_in = s0_ratio_ff;
               shift_in = s0_shift_ff;
            end else if (s0_kind_ff == KIND_NOTE_OFF) begin
               if (s0_note_ff == note_ff) begin
                  active_in = 1'b0;
               end
               vel_in = s0_vel_ff;
            end
         end else if (active_ff) begin
            phase_in = phase_ff + step_ff;
         end
      end
      if (reset) begin
         active_in = 1'b0;
         note_in = '0;
         vel_in = '0;
         ratio_in = SEMITONE_Q16[RESET_SEMI];
         shift_in = RESET_SHIFT;
         base_in = BASE_RESET;
         phase_in = '0;
      end
   end

   always_comb begin
      step_prod = STEP_PROD_BITS'(base_in) * STEP_PROD_BITS'(ratio_in);
      step_shifted = step_prod >> shift_in;
      step_in = (step_shifted > STEP_HALF) ? PHASE_BITS'(STEP_HALF)
                                           : PHASE_BITS'(step_shifted);
   end

   always_comb begin
      tick_in = tick_ff;
      if (s0_go && s0_is_tick) begin
         tick_in.valid = 1'b1;
         tick_in.active = active_ff;
         tick_in.gain = gain_rom[vel_ff];
      end else if (tick_take) begin
         tick_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      active_ff <= active_in;
      note_ff <= note_in;
      vel_ff <= vel_in;
      ratio_ff <= ratio_in;
      shift_ff <= shift_in;
      base_ff <= base_in;
      phase_ff <= phase_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         tick_ff.valid <= 1'b0;
      end else begin
         if (req_go) begin
            s0_valid_ff <= 1'b1;
         end else if (s0_go) begin
            s0_valid_ff <= 1'b0;
         end
         tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s0_op_ff <= req.op;
         s0_kind_ff <= req.status[7:4];
         s0_note_ff <= req.data_one;
         s0_vel_ff <= req.data_two;
         s0_ratio_ff <= SEMITONE_Q16[dec_semi];
         s0_shift_ff <= SHIFT_TOP - SHIFT_BITS'(dec_oct);
      end
      if (s0_go && s0_is_tick) begin
         idx_ff <= phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
      end
   end

   assign tick = tick_ff;
   assign tick_idx = idx_ff;

endmodule

[rtl/msv_wave.sv]
module msv_wave #(
   parameter int SINE_TABLE_BITS = msv_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS = msv_pkg::SAMPLE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  msv_pkg::tick_type          tick,
   input  logic [SINE_TABLE_BITS-1:0] tick_idx,
   output logic                       tick_take,
   msv_rsp_if.source                  rsp
);
   import msv_pkg::*;

   localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
   localparam int QUARTER_DEPTH = (1 << QUARTER_BITS) + 1;
   localparam int MAG_BITS = SAMPLE_BITS - 1;
   localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
   localparam logic [QUARTER_BITS:0] QUARTER_IDX = {1'b1, {QUARTER_BITS{1'b0}}};
   localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (GAIN_BITS - 1);

   logic [MAG_BITS-1:0] quarter_rom [QUARTER_DEPTH];

   logic                 s2_valid_ff;
   logic                 s2_active_ff;
   logic                 s2_neg_ff;
   logic [MAG_BITS-1:0]  s2_mag_ff;
   logic [GAIN_BITS-1:0] s2_gain_ff;

   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;

   logic [1:0]              quadrant;
   logic [QUARTER_BITS:0]   qidx;
   logic [PROD_BITS-1:0]    prod, rounded;
   logic [MAG_BITS-1:0]     amp;
   logic                    s2_load, out_load, out_room, s2_room;

   for (genvar k = 0; k < QUARTER_DEPTH; k++) begin : g_quarter
      assign quarter_rom[k] = MAG_BITS'(quarter_sine(k, SINE_TABLE_BITS, SAMPLE_BITS));
   end

   assign out_room = !out_valid_ff || rsp.ready;
   assign s2_room = !s2_valid_ff || out_room;
   assign tick_take = s2_room;
   assign s2_load = tick.valid && s2_room;
   assign out_load = s2_valid_ff && out_room;

   // odd quadrants read the quarter wave backwards, upper half is negative
   always_comb begin
      quadrant = tick_idx[SINE_TABLE_BITS-1 -: 2];
      qidx = quadrant[0] ? (QUARTER_IDX - (QUARTER_BITS+1)'(tick_idx[QUARTER_BITS-1:0]))
                         : (QUARTER_BITS+1)'(tick_idx[QUARTER_BITS-1:0]);
   end

   always_comb begin
      prod = PROD_BITS'(s2_mag_ff) * PROD_BITS'(s2_gain_ff);
      rounded = (prod + ROUND_HALF) >> GAIN_BITS;
      amp = MAG_BITS'(rounded);
      if (!s2_active_ff) begin
         out_sample_in = '0;
      end else if (s2_neg_ff) begin
         out_sample_in = -$signed({1'b0, amp});
      end else begin
         out_sample_in = $signed({1'b0, amp});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (out_room) begin
            s2_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_active_ff <= tick.active;
         s2_gain_ff <= tick.gain;
         s2_neg_ff <= quadrant[1];
         s2_mag_ff <= quarter_rom[qidx];
      end
      if (out_load) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.sample = out_sample_ff;

endmodule

[rtl/midi_sine_voice_core.sv]
// Monophonic MIDI sine voice. req carries either a MIDI message (op 0: note-on and
// note-off act, other messages are dropped, nothing is returned) or a sample tick
// (op 1), which returns one signed sample on rsp and then advances the phase
// accumulator. One transaction of either kind is taken every clock unless a tick
// stalls; the limit is the phase accumulator, which adds the registered phase step
// once per tick. A tick's sample passes the input, tick (gain lookup), sine lookup
// and gain multiply registers, and the pipeline stalls only while a finished sample
// waits on rsp. The phase step register is loaded at the same clock edge as the note
// of a note-on or a csr write of base_increment. There is no clearing pass after reset.
module midi_sine_voice_core #(
   parameter int SINE_TABLE_BITS = msv_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS = msv_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = msv_pkg::SAMPLE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   msv_req_if.sink   req,
   msv_rsp_if.source rsp,
   msv_csr_if.sink   csr
);
   import msv_pkg::*;

   tick_type                   s1_tick;
   logic [SINE_TABLE_BITS-1:0] s1_idx;
   logic                       tick_take;

   msv_voice #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_voice (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr       (csr),
      .tick_take (tick_take),
      .tick      (s1_tick),
      .tick_idx  (s1_idx)
   );

   msv_wave #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_wave (
      .clock     (clock),
      .reset     (reset),
      .tick      (s1_tick),
      .tick_idx  (s1_idx),
      .tick_take (tick_take),
      .rsp       (rsp)
   );

   // a stalled tick keeps its lookup inputs
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      s1_tick.valid && !tick_take |=> s1_tick.valid && $stable(s1_idx)
                                      && $stable(s1_tick.gain))
      else $error("tick stage changed while stalled");

   // the tick stage only backs up when a sample is stuck on rsp
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !tick_take |-> rsp.valid && !rsp.ready)
      else $error("tick stage stalled without rsp backpressure");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp.valid && !s1_tick.valid)
      else $error("pipeline not empty after reset");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import msv_pkg::*;

   localparam int CLK_HALF_NS = 4;
   localparam int TIMEOUT_NS = 6_000_000;
   localparam int GAP_MAX = 19;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT = 20_000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASES = 16;
   localparam int PHASE_ITEMS = 100;
   localparam int MAX_PRINTED = 40;

   localparam int LUT_BITS = SINE_TABLE_BITS_DEF;
   localparam int LUT_LEN = 1 << LUT_BITS;
   localparam int QUARTER = LUT_LEN / 4;
   localparam int ACC_BITS = PHASE_BITS_DEF;
   localparam int SMP_BITS = SAMPLE_BITS_DEF;
   localparam logic [63:0] FULL_SCALE = (64'd1 << (SMP_BITS - 1)) - 64'd1;
   localparam logic [63:0] STEP_LIMIT = 64'd1 << (ACC_BITS - 1);
   localparam int A4_NOTE = 69;
   localparam int SEMIS_PER_OCTAVE = 12;
   localparam int RATIO_FRAC_BITS = 16;
   localparam logic [BASE_BITS-1:0] BASE_MAX = '1;

   // message kinds the voice drops
   localparam logic [KIND_BITS-1:0] KIND_POLY_PRESSURE = 4'hA;
   localparam logic [KIND_BITS-1:0] KIND_SYSTEM = 4'hF;

   typedef struct packed {
      logic op;
      logic [7:0] status;
      logic [NOTE_BITS-1:0] note;
      logic [VEL_BITS-1:0] vel;
   } voice_req_type;

   typedef struct packed {
      logic load_base;
      logic [BASE_BITS-1:0] base;
      voice_req_type req;
      logic typed;
      logic signed [SMP_BITS-1:0] typed_sample;
   } dir_row_type;

   dir_row_type dir_rows [26] = '{
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b1, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'hFF, 7'd127, 7'd127}, 1'b1, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_POLY_PRESSURE, 4'h5}, 7'd60, 7'd100}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_NOTE_OFF, 4'hC}, 7'd0, 7'd33}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h5A, 7'd85, 7'd42}, 1'b1, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_NOTE_ON, 4'h0}, 7'd69, 7'd127}, 1'b0, 16'sd0},
      // phase has not moved since reset, so the sine is zero
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b1, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'hA7, 7'd1, 7'd2}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_NOTE_OFF, 4'hF}, 7'd70, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_NOTE_OFF, 4'h0}, 7'd69, 7'd64}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b1, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_NOTE_ON, 4'hF}, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_NOTE_ON, 4'h3}, 7'd127, 7'd127}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      // full-scale base on the top note clamps the step to half a cycle
      '{1'b1, BASE_MAX, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b1, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_MIDI, {KIND_SYSTEM, 4'h0}, 7'd127, 7'd127}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b0, 16'sd0},
      '{1'b1, BASE_RESET, '{OP_MIDI, {KIND_NOTE_OFF, 4'h1}, 7'd127, 7'd0}, 1'b0, 16'sd0},
      '{1'b0, 31'd0, '{OP_TICK, 8'h00, 7'd0, 7'd0}, 1'b1, 16'sd0}
   };

   logic clock;
   logic reset;

   msv_req_if req_ch ();
   msv_rsp_if #(.SAMPLE_BITS(SMP_BITS)) rsp_ch ();
   msv_csr_if csr_ch ();

   midi_sine_voice_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // voice state as the predictor sees it
   int sine_lut [LUT_LEN];
   int gain_lut [GAIN_DEPTH];
   logic voice_on;
   logic [NOTE_BITS-1:0] held_note;
   logic [VEL_BITS-1:0] held_vel;
   logic [ACC_BITS-1:0] phase_acc;
   logic [BASE_BITS-1:0] base_step;

   logic signed [SMP_BITS-1:0] expected_samples [$];

   int mismatches = 0;
   int reqs_sent = 0;
   int ticks_sent = 0;
   int samples_checked = 0;
   int loud_samples = 0;
   int base_writes = 0;
   int clamped_steps = 0;
   int long_holds = 0;
   bit src_gaps_on = 1'b1;
   bit sink_stalls_on = 1'b1;
   bit hold_rsp_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d samples outstanding", expected_samples.size());
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      // keep the log short when everything goes wrong
      if (mismatches <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   function automatic voice_req_type mk_item(input logic op, input logic [7:0] status,
                                             input logic [NOTE_BITS-1:0] note,
                                             input logic [VEL_BITS-1:0] vel);
      voice_req_type it;
      it = '{op, status, note, vel};
      return it;
   endfunction

   // updates the voice state for one transaction and computes the sample of a tick
   task automatic advance_voice(input voice_req_type it, output bit has_smp,
                                output logic signed [SMP_BITS-1:0] smp);
      int d;
      int octave;
      int semi;
      int sval;
      int lut_idx;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] scaled;
      logic [63:0] step;
      has_smp = 1'b0;
      smp = '0;
      if (it.op == OP_MIDI) begin
         if (it.status[7:4] == KIND_NOTE_ON) begin
            held_note = it.note;
            held_vel = it.vel;
            voice_on = 1'b1;
         end else if (it.status[7:4] == KIND_NOTE_OFF) begin
            if (it.note == held_note) voice_on = 1'b0;
            held_vel = it.vel;
         end
      end else begin
         has_smp = 1'b1;
         if (voice_on) begin
            lut_idx = int'(phase_acc >> (ACC_BITS - LUT_BITS));
            sval = sine_lut[lut_idx];
            mag = (sval < 0) ? 64'(-sval) : 64'(sval);
            prod = (mag * 64'(gain_lut[held_vel]) + 64'd16384) >> 15;
            smp = (sval < 0) ? SMP_BITS'(-prod) : SMP_BITS'(prod);
            if (smp != 0) loud_samples++;
            d = int'(held_note) - A4_NOTE;
            octave = (d >= 0) ? d / SEMIS_PER_OCTAVE
                              : -((SEMIS_PER_OCTAVE - 1 - d) / SEMIS_PER_OCTAVE);
            semi = d - SEMIS_PER_OCTAVE * octave;
            scaled = 64'(base_step) * 64'(SEMITONE_Q16[semi]);
            step = scaled >> (RATIO_FRAC_BITS - octave);
            if (step > STEP_LIMIT) begin
               step = STEP_LIMIT;
               clamped_steps++;
            end
            phase_acc = phase_acc + step[ACC_BITS-1:0];
         end
      end
   endtask

   task automatic send_req(input voice_req_type it, input bit use_typed,
                           input logic signed [SMP_BITS-1:0] typed_smp);
      int gap;
      bit has_smp;
      logic signed [SMP_BITS-1:0] smp;
      gap = src_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         req_ch.op = 1'($urandom);
         req_ch.status = 8'($urandom);
         req_ch.data_one = NOTE_BITS'($urandom);
         req_ch.data_two = VEL_BITS'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.op = it.op;
      req_ch.status = it.status;
      req_ch.data_one = it.note;
      req_ch.data_two = it.vel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_voice(it, has_smp, smp);
      if (has_smp) begin
         expected_samples.push_back(use_typed ? typed_smp : smp);
         ticks_sent++;
      end
      reqs_sent++;
   endtask

   // drop valid, let every outstanding sample come back, then let midi
   // transactions still in the pipe settle
   task automatic wait_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_BITS-1:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.base_increment = value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      base_step = value;
      base_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // note-on, a burst of ticks with some stray messages, then usually a note-off
   task automatic play_phrase(inout int sent);
      int ending;
      logic [KIND_BITS-1:0] nib;
      logic [NOTE_BITS-1:0] off_note;
      voice_req_type it;
      // now and then a phrase with no note-on in front
      if ($urandom_range(0, 7) != 0) begin
         it = mk_item(OP_MIDI, {KIND_NOTE_ON, 4'($urandom)}, NOTE_BITS'($urandom),
                      VEL_BITS'($urandom));
         send_req(it, 1'b0, '0);
         sent++;
      end
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(0, 7) == 0) begin
            nib = 4'($urandom_range(0, 13));
            if (nib >= KIND_NOTE_OFF) nib = nib + 4'd2;
            it = mk_item(OP_MIDI, {nib, 4'($urandom)}, NOTE_BITS'($urandom),
                         VEL_BITS'($urandom));
         end else begin
            it = mk_item(OP_TICK, 8'($urandom), NOTE_BITS'($urandom), VEL_BITS'($urandom));
         end
         send_req(it, 1'b0, '0);
         sent++;
      end
      ending = $urandom_range(0, 3);
      if (ending < 3) begin
         off_note = (ending == 0) ? held_note + NOTE_BITS'($urandom_range(1, 127)) : held_note;
         it = mk_item(OP_MIDI, {KIND_NOTE_OFF, 4'($urandom)}, off_note, VEL_BITS'($urandom));
         send_req(it, 1'b0, '0);
         sent++;
         repeat ($urandom_range(0, 3)) begin
            it = mk_item(OP_TICK, 8'($urandom), NOTE_BITS'($urandom), VEL_BITS'($urandom));
            send_req(it, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // output side: random stalls, one long hold on request, checks every sample
   initial begin
      int stall;
      logic signed [SMP_BITS-1:0] want;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = sink_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
            long_holds++;
         end
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d with nothing expected", rsp_ch.sample));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_ch.sample !== want) begin
               report_mismatch($sformatf("sample %0d, expected %0d", rsp_ch.sample, want));
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      logic [63:0] ang;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] amp;
      logic [63:0] g;
      int m;
      int sent;
      bit paused;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = OP_MIDI;
      req_ch.status = '0;
      req_ch.data_one = '0;
      req_ch.data_two = '0;
      csr_ch.valid = 1'b0;
      csr_ch.base_increment = '0;

      voice_on = 1'b0;
      held_note = '0;
      held_vel = '0;
      phase_acc = '0;
      base_step = BASE_RESET;

      // quarter-wave taylor series on a q2.30 angle, mirrored to a full cycle
      for (int k = 0; k < LUT_LEN; k++) begin
         m = ((k / QUARTER) % 2 == 1) ? QUARTER - (k % QUARTER) : k % QUARTER;
         ang = (64'(m) * PI_Q30) >> (LUT_BITS - 1);
         x2 = (ang * ang) >> 30;
         t = Q30_ONE;
         t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
         t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         t = (ang * t) >> 30;
         if (t > Q30_ONE) t = Q30_ONE;
         amp = (t * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
         sine_lut[k] = (k / QUARTER >= 2) ? -int'(amp) : int'(amp);
      end
      // -60 db at velocity 0, rising by 54/127 db per step
      g = GAIN_START;
      for (int k = 0; k < GAIN_DEPTH; k++) begin
         gain_lut[k] = int'((g + 64'd65536) >> 17);
         g = (g * GAIN_RATIO + (Q30_ONE >> 1)) >> 30;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].load_base) begin
            wait_idle();
            write_base(dir_rows[i].base);
         end
         send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].typed_sample);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p % 6)
            0: write_base(BASE_RESET);
            1: write_base(BASE_BITS'($urandom));
            2: write_base(BASE_BITS'($urandom_range(1000, 100_000_000)));
            3: write_base(BASE_MAX);
            4: write_base('0);
            default: write_base(BASE_BITS'($urandom_range(10_000_000, 400_000_000)));
         endcase
         src_gaps_on = (p % 3 != 2);
         sink_stalls_on = (p % 4 != 1);
         // back-to-back transactions against a stalled output fill the pipe
         if (p == 2) hold_rsp_request = 1'b1;
         sent = 0;
         paused = 1'b0;
         while (sent < PHASE_ITEMS) begin
            play_phrase(sent);
            if (p == 4 && !paused && sent >= PHASE_ITEMS / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end

      wait_idle();
      if (expected_samples.size() != 0) begin
         report_mismatch($sformatf("%0d expected samples never arrived",
                                   expected_samples.size()));
      end
      $display("run covered %0d requests (%0d ticks), %0d samples checked, %0d nonzero",
               reqs_sent, ticks_sent, samples_checked, loud_samples);
      $display("base_increment written %0d times, %0d clamped steps, %0d long output holds",
               base_writes, clamped_steps, long_holds);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
